/* sv/qye_pkg.sv */
`default_nettype none

package qye_pkg;

  localparam int unsigned QW            = 16;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned SC_W          = 34;
  localparam int unsigned NORM_W        = 40;
  localparam int unsigned CW            = 44;
  localparam int unsigned AW            = 32;
  localparam int unsigned SH_W          = 6;
  localparam int unsigned YAW_W         = 16;
  localparam int unsigned NORM_MSB      = 38;
  localparam int unsigned ANG_FRAC      = 16;
  localparam int unsigned FRONT_STAGES  = 4;
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam logic signed [SC_W-1:0] ONE_Q28   = 34'sd268435456;
  localparam logic signed [AW-1:0]   ANG_90    = 32'sd589824000;
  localparam logic [YAW_W:0]         YAW_LIMIT = 17'd18000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } cord_t;

  // atan(2^-i) in units of 2^-16 centidegree
  function automatic logic signed [AW-1:0] atan_lut(input int unsigned idx);
    logic signed [AW-1:0] v;
    unique case (idx)
      0:       v = 32'sd294912000;
      1:       v = 32'sd174096719;
      2:       v = 32'sd91987925;
      3:       v = 32'sd46694507;
      4:       v = 32'sd23437865;
      5:       v = 32'sd11730358;
      6:       v = 32'sd5866610;
      7:       v = 32'sd2933484;
      8:       v = 32'sd1466764;
      9:       v = 32'sd733385;
      10:      v = 32'sd366693;
      11:      v = 32'sd183346;
      12:      v = 32'sd91673;
      13:      v = 32'sd45837;
      14:      v = 32'sd22918;
      15:      v = 32'sd11459;
      16:      v = 32'sd5730;
      17:      v = 32'sd2865;
      18:      v = 32'sd1432;
      19:      v = 32'sd716;
      20:      v = 32'sd358;
      21:      v = 32'sd179;
      22:      v = 32'sd90;
      23:      v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/qye_front.sv */
`default_nettype none

module qye_front (
  input  wire logic                                clk_i,
  input  wire logic [qye_pkg::FRONT_STAGES-1:0]    en_i,
  input  wire logic signed [qye_pkg::QW-1:0]       quat_w_i,
  input  wire logic signed [qye_pkg::QW-1:0]       quat_x_i,
  input  wire logic signed [qye_pkg::QW-1:0]       quat_y_i,
  input  wire logic signed [qye_pkg::QW-1:0]       quat_z_i,
  output qye_pkg::cord_t                           vec_o
);

  // stage 1: products
  logic signed [qye_pkg::PROD_W-1:0] pwz_q, pxy_q, pyy_q, pzz_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pwz_q <= qye_pkg::PROD_W'(quat_w_i) * qye_pkg::PROD_W'(quat_z_i);
      pxy_q <= qye_pkg::PROD_W'(quat_x_i) * qye_pkg::PROD_W'(quat_y_i);
      pyy_q <= qye_pkg::PROD_W'(quat_y_i) * qye_pkg::PROD_W'(quat_y_i);
      pzz_q <= qye_pkg::PROD_W'(quat_z_i) * qye_pkg::PROD_W'(quat_z_i);
    end
  end

  // stage 2: S = 2(wz+xy), C = 1 - 2(y^2+z^2), Q28
  logic signed [qye_pkg::SC_W-1:0] s2_d, c2_d, s2_q, c2_q;
  logic [qye_pkg::PROD_W:0]        sum_sc;
  logic [qye_pkg::PROD_W-1:0]      sum_sq;

  always_comb begin
    sum_sc = {pwz_q[qye_pkg::PROD_W-1], pwz_q} + {pxy_q[qye_pkg::PROD_W-1], pxy_q};
    s2_d   = $signed({sum_sc, 1'b0});
    sum_sq = {1'b0, pyy_q[qye_pkg::PROD_W-2:0]} + {1'b0, pzz_q[qye_pkg::PROD_W-2:0]};
    c2_d   = qye_pkg::ONE_Q28 - $signed({1'b0, sum_sq, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s2_d;
      c2_q <= c2_d;
    end
  end

  // stage 3: normalizing shift from the leading one of |S| | |C|
  logic [qye_pkg::SC_W-1:0]        mag_s, mag_c, mag_or;
  logic [qye_pkg::SH_W-1:0]        msb, sh3_d, sh3_q;
  logic                            zero3_d, zero3_q;
  logic signed [qye_pkg::SC_W-1:0] s3_q, c3_q;

  always_comb begin
    mag_s   = s2_q[qye_pkg::SC_W-1] ? -s2_q : s2_q;
    mag_c   = c2_q[qye_pkg::SC_W-1] ? -c2_q : c2_q;
    mag_or  = mag_s | mag_c;
    zero3_d = ~|mag_or;
    msb     = '0;
    for (int b = 0; b < qye_pkg::SC_W; b++) begin
      if (mag_or[b]) begin
        msb = qye_pkg::SH_W'(b);
      end
    end
    sh3_d = qye_pkg::SH_W'(qye_pkg::NORM_MSB) - msb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_q    <= s2_q;
      c3_q    <= c2_q;
      sh3_q   <= sh3_d;
      zero3_q <= zero3_d;
    end
  end

  // stage 4: shift, then turn left-half-plane vectors by 90 degrees
  logic signed [qye_pkg::NORM_W-1:0] xn, yn;
  logic signed [qye_pkg::CW-1:0]     xw, yw;
  qye_pkg::cord_t                    vec_d, vec_q;

  always_comb begin
    xn = qye_pkg::NORM_W'(c3_q) <<< sh3_q;
    yn = qye_pkg::NORM_W'(s3_q) <<< sh3_q;
    xw = qye_pkg::CW'(xn);
    yw = qye_pkg::CW'(yn);
    vec_d.zero = zero3_q;
    if (!xw[qye_pkg::CW-1]) begin
      vec_d.x = xw;
      vec_d.y = yw;
      vec_d.z = '0;
    end else if (!yw[qye_pkg::CW-1]) begin
      vec_d.x = yw;
      vec_d.y = -xw;
      vec_d.z = qye_pkg::ANG_90;
    end else begin
      vec_d.x = -yw;
      vec_d.y = xw;
      vec_d.z = -qye_pkg::ANG_90;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

/* sv/qye_cordic_stage.sv */
`default_nettype none

module qye_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire qye_pkg::cord_t vec_i,
  output qye_pkg::cord_t      vec_o
);

  localparam logic signed [qye_pkg::AW-1:0] ANG = qye_pkg::atan_lut(SHIFT);

  logic signed [qye_pkg::CW-1:0] dx, dy;
  qye_pkg::cord_t                vec_d, vec_q;

  always_comb begin
    dx         = vec_i.y >>> SHIFT;
    dy         = vec_i.x >>> SHIFT;
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[qye_pkg::CW-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ANG;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

/* sv/qye_round.sv */
`default_nettype none

module qye_round (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire qye_pkg::cord_t                vec_i,
  output logic signed [qye_pkg::YAW_W-1:0]   yaw_o
);

  logic                            neg;
  logic [qye_pkg::AW-1:0]          mag;
  logic [qye_pkg::AW:0]            rnd;
  logic [qye_pkg::YAW_W:0]         r;
  logic signed [qye_pkg::YAW_W-1:0] yaw_d, yaw_q;

  // round half away from zero, then clamp to +-180 degrees
  always_comb begin
    neg = vec_i.z[qye_pkg::AW-1];
    mag = neg ? -vec_i.z : vec_i.z;
    rnd = {1'b0, mag} + (qye_pkg::AW+1)'(1 << (qye_pkg::ANG_FRAC - 1));
    r   = rnd[qye_pkg::AW:qye_pkg::ANG_FRAC];
    if (r > qye_pkg::YAW_LIMIT) begin
      r = qye_pkg::YAW_LIMIT;
    end
    if (vec_i.zero) begin
      yaw_d = '0;
    end else if (neg) begin
      yaw_d = -$signed(r[qye_pkg::YAW_W-1:0]);
    end else begin
      yaw_d = $signed(r[qye_pkg::YAW_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yaw_q <= yaw_d;
    end
  end

  assign yaw_o = yaw_q;

endmodule

`default_nettype wire

/* sv/quaternion_yaw_extractor_unit.sv */
// Channel  Direction  Handshake               Payload
// in       receive    in_valid_i / in_stall_o quat_w_i, quat_x_i, quat_y_i, quat_z_i
// out      send       out_valid_o / out_stall_i yaw_centideg_o
//
// Pipeline: products, sums, normalize, shift/turn, one register per CORDIC
// iteration, rounding into the output register. Each stage has its own valid bit.
// Throughput: one transaction per cycle while out_stall_i is low.
// Stall: a stage holds only while it is full and the stage after it holds, so
// bubbles close up and input is taken while a result waits, until all are full.
// Reset clears the valid bits only.
`default_nettype none

module quaternion_yaw_extractor_unit #(
  parameter int unsigned CORDIC_STAGES = qye_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [qye_pkg::QW-1:0]      quat_w_i,
  input  wire logic signed [qye_pkg::QW-1:0]      quat_x_i,
  input  wire logic signed [qye_pkg::QW-1:0]      quat_y_i,
  input  wire logic signed [qye_pkg::QW-1:0]      quat_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [qye_pkg::YAW_W-1:0]        yaw_centideg_o
);

  localparam int unsigned DEPTH = qye_pkg::FRONT_STAGES + CORDIC_STAGES + 1;

  logic [DEPTH-1:0] v_q, v_d;
  logic [DEPTH:0]   rdy;

  always_comb begin
    rdy[DEPTH] = ~out_stall_i;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (rdy[k]) begin
        v_d[k] = (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = ~rdy[0];
  assign out_valid_o = v_q[DEPTH-1];

  qye_pkg::cord_t chain [CORDIC_STAGES+1];

  qye_front u_front (
    .clk_i    (clk_i),
    .en_i     (rdy[qye_pkg::FRONT_STAGES-1:0]),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .vec_o    (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qye_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (rdy[qye_pkg::FRONT_STAGES + i]),
      .vec_i (chain[i]),
      .vec_o (chain[i+1])
    );
  end

  qye_round u_round (
    .clk_i (clk_i),
    .en_i  (rdy[DEPTH-1]),
    .vec_i (chain[CORDIC_STAGES]),
    .yaw_o (yaw_centideg_o)
  );

`ifndef SYNTHESIS
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted transaction not in first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &v_q)
    else $error("input stalled with a bubble in the pipeline");

  a_drain_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_centideg_o <= 16'sd18000) && (yaw_centideg_o >= -16'sd18000))
    else $error("yaw out of range");
`endif

endmodule

`default_nettype wire

/* bench/quaternion_yaw_extractor_unit_tb.sv */
`default_nettype none

module quaternion_yaw_extractor_unit_tb;

  localparam int unsigned STAGES     = qye_pkg::CORDIC_STAGES_DEF;
  localparam int unsigned LATENCY    = 4 + STAGES + 1;
  localparam int unsigned RAND_ITEMS = 2000;
  localparam int unsigned STUCK_MAX  = 2000;
  localparam int unsigned DIR_ROWS   = 23;
  localparam int unsigned CALM_FROM  = 600;
  localparam int unsigned CALM_TO    = 1000;
  localparam longint      NORM_LIM   = longint'(1) << qye_pkg::NORM_MSB;
  localparam longint      ANGLE_90   = 64'sd589824000;
  localparam longint      YAW_MAX    = 18000;

  typedef struct packed {
    logic signed [qye_pkg::QW-1:0]    w;
    logic signed [qye_pkg::QW-1:0]    x;
    logic signed [qye_pkg::QW-1:0]    y;
    logic signed [qye_pkg::QW-1:0]    z;
    bit                               fixed;
    logic signed [qye_pkg::YAW_W-1:0] yaw;
  } quat_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic signed [qye_pkg::QW-1:0]    quat_w_i = '0;
  logic signed [qye_pkg::QW-1:0]    quat_x_i = '0;
  logic signed [qye_pkg::QW-1:0]    quat_y_i = '0;
  logic signed [qye_pkg::QW-1:0]    quat_z_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [qye_pkg::YAW_W-1:0] yaw_centideg_o;

  // atan(2^-i), 2^-16 centidegree units
  longint atan_step_ang [qye_pkg::ATAN_LEN] = '{
    294912000, 174096719, 91987925, 46694507,
    23437865, 11730358, 5866610, 2933484,
    1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716,
    358, 179, 90, 45
  };

  quat_row_t dir_rows [DIR_ROWS] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd100, -16'sd100, 16'sd8192, 16'sd8192, 1'b1, 16'sd0},
    '{16'sd7, 16'sd7, -16'sd8192, 16'sd8192, 1'b1, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b1, 16'sd18000},
    '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b1, 16'sd18000},
    '{16'sd0, 16'sd0, 16'h8000, 16'sd0, 1'b1, 16'sd18000},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'sd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'sd0},
    '{16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 1'b0, 16'sd0},
    '{16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 1'b0, 16'sd0},
    '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, 16'sd0},
    '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 1'b0, 16'sd0},
    '{16'sd1, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0},
    '{-16'sd1, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0},
    '{16'sd0, 16'sd1, -16'sd1, 16'sd16384, 1'b0, 16'sd0},
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd1, 1'b0, 16'sd0},
    '{16'sd16384, 16'sd0, 16'sd0, -16'sd1, 1'b0, 16'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b0, 16'sd0},
    '{16'h8000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd8192, 16'sd8191, 1'b0, 16'sd0}
  };

  logic signed [qye_pkg::YAW_W-1:0] yaw_expected_q [$];
  int unsigned                      mismatch_cnt = 0;
  int unsigned                      stuck_cycles = 0;
  bit                               calm = 1'b0;

  quaternion_yaw_extractor_unit #(
    .CORDIC_STAGES (STAGES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .yaw_centideg_o (yaw_centideg_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic signed [qye_pkg::YAW_W-1:0] yaw_of_quat(
    input logic signed [qye_pkg::QW-1:0] qw,
    input logic signed [qye_pkg::QW-1:0] qx,
    input logic signed [qye_pkg::QW-1:0] qy,
    input logic signed [qye_pkg::QW-1:0] qz
  );
    longint s_v, c_v, vx, vy, ang, t, dx, dy, r, half;
    half = longint'(1) << (qye_pkg::ANG_FRAC - 1);
    s_v = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
    c_v = (longint'(1) << 28) - 2 * (longint'(qy) * longint'(qy) +
                                     longint'(qz) * longint'(qz));
    ang = 0;
    if (s_v != 0 || c_v != 0) begin
      vx = c_v;
      vy = s_v;
      while (((vx < 0) ? -vx : vx) < NORM_LIM && ((vy < 0) ? -vy : vy) < NORM_LIM) begin
        vx = vx * 2;
        vy = vy * 2;
      end
      // left half plane: quarter turn first
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx = vy;
          vy = -t;
          ang = ANGLE_90;
        end else begin
          vx = -vy;
          vy = t;
          ang = -ANGLE_90;
        end
      end
      for (int i = 0; i < STAGES && i < qye_pkg::ATAN_LEN; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          ang = ang + atan_step_ang[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          ang = ang - atan_step_ang[i];
        end
      end
    end
    if (ang >= 0) begin
      r = (ang + half) >>> qye_pkg::ANG_FRAC;
    end else begin
      r = -((-ang + half) >>> qye_pkg::ANG_FRAC);
    end
    if (r > YAW_MAX) r = YAW_MAX;
    if (r < -YAW_MAX) r = -YAW_MAX;
    return r[qye_pkg::YAW_W-1:0];
  endfunction

  function automatic quat_row_t random_quat();
    quat_row_t q;
    int unsigned mode;
    q = '0;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      q.w = qye_pkg::QW'($urandom);
      q.x = qye_pkg::QW'($urandom);
      q.y = qye_pkg::QW'($urandom);
      q.z = qye_pkg::QW'($urandom);
    end else if (mode <= 6) begin
      q.w = qye_pkg::QW'(int'($urandom_range(32768)) - 16384);
      q.x = qye_pkg::QW'(int'($urandom_range(32768)) - 16384);
      q.y = qye_pkg::QW'(int'($urandom_range(32768)) - 16384);
      q.z = qye_pkg::QW'(int'($urandom_range(32768)) - 16384);
    end else if (mode == 7) begin
      // sine term zero, cosine term either sign
      q.x = qye_pkg::QW'($urandom);
      q.z = qye_pkg::QW'($urandom);
    end else if (mode == 8) begin
      // cosine term zero
      q.w = qye_pkg::QW'($urandom);
      q.x = qye_pkg::QW'($urandom);
      q.y = $urandom_range(1) ? 16'sd8192 : -16'sd8192;
      q.z = $urandom_range(1) ? 16'sd8192 : -16'sd8192;
    end else begin
      q.w = qye_pkg::QW'(int'($urandom_range(8)) - 4);
      q.x = qye_pkg::QW'(int'($urandom_range(8)) - 4);
      q.y = qye_pkg::QW'(int'($urandom_range(8)) - 4);
      q.z = qye_pkg::QW'(int'($urandom_range(8)) - 4);
    end
    return q;
  endfunction

  task automatic send_quat(input quat_row_t q);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i   <= q.w;
    quat_x_i   <= q.x;
    quat_y_i   <= q.y;
    quat_z_i   <= q.z;
    do @(posedge clk_i); while (in_stall_o);
    yaw_expected_q.push_back(q.fixed ? q.yaw : yaw_of_quat(q.w, q.x, q.y, q.z));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (yaw_expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, yaw %0d", $time, yaw_centideg_o);
        mismatch_cnt <= mismatch_cnt + 1;
      end else begin
        if (yaw_centideg_o !== yaw_expected_q[0]) begin
          $display("%0t: yaw_centideg mismatch, expected %0d, actual %0d",
                   $time, yaw_expected_q[0], yaw_centideg_o);
          mismatch_cnt <= mismatch_cnt + 1;
        end
        void'(yaw_expected_q.pop_front());
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
        $display("quaternion_yaw_extractor_unit test failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_quat(dir_rows[i]);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= CALM_FROM && n < CALM_TO);
      send_quat(random_quat());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (yaw_expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && yaw_expected_q.size() == 0) begin
      $display("quaternion_yaw_extractor_unit test passed");
    end else begin
      $display("quaternion_yaw_extractor_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/qye_pkg.sv
sv/qye_front.sv
sv/qye_cordic_stage.sv
sv/qye_round.sv
sv/quaternion_yaw_extractor_unit.sv
bench/quaternion_yaw_extractor_unit_tb.sv
